[src/lrp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the link recovery policy block
// no dependencies; imported by every module of the block
package lrp_pkg;

	// request codes
	localparam logic [1:0] REQ_EVALUATE = 2'd0;
	localparam logic [1:0] REQ_REDIAL_RESULT = 2'd1;
	localparam logic [1:0] REQ_RESTART_DONE = 2'd2;
	localparam logic [1:0] REQ_CANCEL = 2'd3;

	// decision codes
	localparam logic [3:0] DEC_HEALTHY = 4'd0;
	localparam logic [3:0] DEC_ALT = 4'd1;
	localparam logic [3:0] DEC_UPDATE = 4'd2;
	localparam logic [3:0] DEC_COVERAGE = 4'd3;
	localparam logic [3:0] DEC_SESSION = 4'd4;
	localparam logic [3:0] DEC_REDIAL = 4'd5;
	localparam logic [3:0] DEC_RECOVER = 4'd6;
	localparam logic [3:0] DEC_RESTART = 4'd7;
	localparam logic [3:0] DEC_COOLDOWN = 4'd8;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SESSION_UNHEALTHY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_RESET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REDIALS_BEFORE_RESTART = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESTART_COOLDOWN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_WINDOW = 3'd4;

	// configuration reset values
	localparam logic [31:0] RST_SESSION_UNHEALTHY = 32'd120000;
	localparam logic [31:0] RST_STABLE_RESET = 32'd300000;
	localparam logic [7:0] RST_REDIALS_BEFORE_RESTART = 8'd3;
	localparam logic [31:0] RST_RESTART_COOLDOWN = 32'd600000;
	localparam logic [31:0] RST_ATTEMPT_WINDOW = 32'd60000;

	localparam logic [7:0] FAIL_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic [47:0] now_ms;
		logic update_active;
		logic session_connected;
		logic ack_seen;
		logic [47:0] last_ack_ms;
		logic alt_uplink_ok;
		logic network_attached;
		logic data_link_up;
		logic modem_answering;
		logic recovered;
	} lrp_in_t;

	typedef struct packed {
		logic [3:0] decision;
		logic [7:0] failure_count;
	} lrp_out_t;

	typedef struct packed {
		logic [31:0] session_unhealthy_ms;
		logic [31:0] stable_reset_ms;
		logic [7:0] redials_before_restart;
		logic [31:0] restart_cooldown_ms;
		logic [31:0] attempt_window_ms;
	} lrp_cfg_t;

endpackage

[src/lrp_cfg_regs.sv]
`timescale 1ns / 1ps
// configuration register file of the link recovery policy
// depends on lrp_pkg
module lrp_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output lrp_pkg::lrp_cfg_t cfg_q
);
	import lrp_pkg::*;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.session_unhealthy_ms <= RST_SESSION_UNHEALTHY;
			cfg_q.stable_reset_ms <= RST_STABLE_RESET;
			cfg_q.redials_before_restart <= RST_REDIALS_BEFORE_RESTART;
			cfg_q.restart_cooldown_ms <= RST_RESTART_COOLDOWN;
			cfg_q.attempt_window_ms <= RST_ATTEMPT_WINDOW;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SESSION_UNHEALTHY: cfg_q.session_unhealthy_ms <= cfg_data;
				CFG_STABLE_RESET: cfg_q.stable_reset_ms <= cfg_data;
				CFG_REDIALS_BEFORE_RESTART: cfg_q.redials_before_restart <= cfg_data[7:0];
				CFG_RESTART_COOLDOWN: cfg_q.restart_cooldown_ms <= cfg_data;
				CFG_ATTEMPT_WINDOW: cfg_q.attempt_window_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[src/lrp_policy_core.sv]
`timescale 1ns / 1ps
// decision logic and kept timers of the link recovery policy
// depends on lrp_pkg; fed from the input register of the top level
module lrp_policy_core (
	input logic clk,
	input logic arst_n,
	input logic step,
	input lrp_pkg::lrp_in_t item,
	input lrp_pkg::lrp_cfg_t cfg,
	output lrp_pkg::lrp_out_t result
);
	import lrp_pkg::*;

	logic stable_valid_q;
	logic [47:0] stable_since_q;
	logic deadline_valid_q;
	logic [48:0] attempt_deadline_q;
	logic restart_valid_q;
	logic [47:0] last_restart_q;
	logic [7:0] failed_count_q;

	logic stable_valid_n;
	logic [47:0] stable_since_n;
	logic deadline_valid_n;
	logic [48:0] attempt_deadline_n;
	logic restart_valid_n;
	logic [47:0] last_restart_n;
	logic [7:0] failed_count_n;
	logic [3:0] decision;

	logic [47:0] ack_age;
	logic fresh;
	logic [47:0] stable_age;
	logic stable_elapsed;
	logic [47:0] restart_age;
	logic cooldown_elapsed;
	logic [48:0] deadline_sum;
	logic in_attempt;

	always_comb begin
		ack_age = item.now_ms - item.last_ack_ms;
		fresh = item.ack_seen && (item.now_ms >= item.last_ack_ms)
			&& (ack_age < {16'd0, cfg.session_unhealthy_ms});
		stable_age = item.now_ms - stable_since_q;
		// a fresh stable start elapses at once only for a zero threshold
		stable_elapsed = stable_valid_q
			? ((item.now_ms >= stable_since_q) && (stable_age >= {16'd0, cfg.stable_reset_ms}))
			: (cfg.stable_reset_ms == 32'd0);
		restart_age = item.now_ms - last_restart_q;
		cooldown_elapsed = (item.now_ms >= last_restart_q)
			&& (restart_age >= {16'd0, cfg.restart_cooldown_ms});
		deadline_sum = {1'b0, item.now_ms} + {17'd0, cfg.attempt_window_ms};
		in_attempt = deadline_valid_q && ({1'b0, item.now_ms} < attempt_deadline_q);
	end

	always_comb begin
		stable_valid_n = stable_valid_q;
		stable_since_n = stable_since_q;
		deadline_valid_n = deadline_valid_q;
		attempt_deadline_n = attempt_deadline_q;
		restart_valid_n = restart_valid_q;
		last_restart_n = last_restart_q;
		failed_count_n = failed_count_q;
		decision = DEC_HEALTHY;
		case (item.req_type)
			REQ_EVALUATE: begin
				if (item.update_active) begin
					deadline_valid_n = 1'b0;
					stable_valid_n = 1'b0;
					decision = DEC_UPDATE;
				end else if (item.session_connected && fresh) begin
					stable_valid_n = 1'b1;
					if (!stable_valid_q)
						stable_since_n = item.now_ms;
					if (stable_elapsed)
						failed_count_n = 8'd0;
					decision = DEC_HEALTHY;
				end else begin
					stable_valid_n = 1'b0;
					if (item.alt_uplink_ok) begin
						decision = DEC_ALT;
					end else if (!item.network_attached) begin
						deadline_valid_n = 1'b0;
						decision = DEC_COVERAGE;
					end else if (!item.data_link_up || fresh) begin
						decision = DEC_SESSION;
					end else if (in_attempt) begin
						decision = DEC_RECOVER;
					end else if ((failed_count_q >= cfg.redials_before_restart)
						&& item.modem_answering) begin
						decision = (restart_valid_q && !cooldown_elapsed)
							? DEC_COOLDOWN : DEC_RESTART;
					end else begin
						deadline_valid_n = 1'b1;
						attempt_deadline_n = deadline_sum;
						decision = DEC_REDIAL;
					end
				end
			end
			REQ_REDIAL_RESULT: begin
				deadline_valid_n = 1'b0;
				if (item.recovered) begin
					stable_valid_n = 1'b1;
					stable_since_n = item.now_ms;
				end else if (failed_count_q != FAIL_MAX) begin
					failed_count_n = failed_count_q + 8'd1;
				end
			end
			REQ_RESTART_DONE: begin
				restart_valid_n = 1'b1;
				last_restart_n = item.now_ms;
				deadline_valid_n = 1'b1;
				attempt_deadline_n = deadline_sum;
			end
			default: begin
				deadline_valid_n = 1'b0;
			end
		endcase
		result.decision = decision;
		result.failure_count = failed_count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_valid_q <= 1'b0;
			deadline_valid_q <= 1'b0;
			restart_valid_q <= 1'b0;
			failed_count_q <= 8'd0;
		end else if (step) begin
			stable_valid_q <= stable_valid_n;
			deadline_valid_q <= deadline_valid_n;
			restart_valid_q <= restart_valid_n;
			failed_count_q <= failed_count_n;
		end
	end

	// timestamps are only read while their valid flag is set
	always_ff @(posedge clk) begin
		if (step) begin
			stable_since_q <= stable_since_n;
			attempt_deadline_q <= attempt_deadline_n;
			last_restart_q <= last_restart_n;
		end
	end

endmodule

[src/link_recovery_policy.sv]
`timescale 1ns / 1ps
// link recovery policy top level: input register, policy core, result register
// an evaluate word passes the input register, then the result register, to out_data
// throughput: one word per cycle while no evaluate word waits on a stalled output;
// kept timers update once per word in the core; other request words give no result
// reset: arst_n clears pipeline valids and timer flags, config returns to defaults
module link_recovery_policy (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lrp_pkg::lrp_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lrp_pkg::lrp_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import lrp_pkg::*;

	lrp_cfg_t cfg_q;
	logic valid_s1;
	lrp_in_t item_s1;
	logic out_valid_q;
	lrp_out_t out_data_q;
	lrp_out_t result;
	logic is_eval;
	logic out_free;
	logic advance;
	logic load_s1;

	lrp_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg_q(cfg_q)
	);

	lrp_policy_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.cfg(cfg_q),
		.result(result)
	);

	assign is_eval = (item_s1.req_type == REQ_EVALUATE);
	assign out_free = !out_valid_q || !out_stall;
	// only evaluate words need room in the result register
	assign advance = valid_s1 && (!is_eval || out_free);
	assign load_s1 = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= in_valid;
			if (advance && is_eval)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid)
			item_s1 <= in_data;
		if (advance && is_eval)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && is_eval && out_valid_q && out_stall))
		else $error("input stalled without a blocked evaluate word");

	a_no_result_for_update: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !is_eval && !out_valid_q) |=> !out_valid_q)
		else $error("non-evaluate word produced a result");

	a_decision_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.decision <= DEC_COOLDOWN))
		else $error("decision code out of range");

	a_eval_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_eval) |=> (out_valid_q && out_data_q == $past(result)))
		else $error("evaluate result not captured");

endmodule
